// ===== sv/postfix_stack_evaluator_assert.svh =====
// Assertion macros for the postfix stack evaluator checker.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PSE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PSE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pse_pkg.sv =====
// Shared types and constants of the postfix stack evaluator.
// Used by the top level and by its assertion checker; no dependencies.
`timescale 1ns / 1ps

package pse_pkg;

	// Default configuration
	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed field widths
	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int DEPTH_W  = 5;
	localparam int STATUS_W = 3;

	// Saturation limits of a Q-format word
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_DIVZERO   = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_MULT,
		S_DIVIDE,
		S_DIV_FIN
	} state_t;

endpackage

// ===== sv/postfix_stack_evaluator.sv =====
// Postfix stack evaluator: RPN calculator over a stack held in a synchronous memory.
// Depends on pse_pkg (types, codes, defaults).
//
// Usage:
//   Input channel (op_valid / op_stall): one word carries operation and value.
//   Operation 0 pushes value; 1..4 replace the two top entries a (second) and
//   b (top) by a+b, a-b, a*b or a/b in signed fixed point with FRAC_BITS
//   fraction bits. Codes 5..7 leave the stack as it is.
//   Result channel (res_valid / res_stall): one word per input word, carrying
//   the top entry (zero when empty), the entry count and a status code.
//   Flow of a word: an accepted word is latched, then S_READ reads the two top
//   entries of the stack memory through its two read ports and S_EXEC works on
//   it. Push, add, subtract, unknown codes and every error case (operator
//   underflow, push on a full stack, zero divisor) finish from S_EXEC; multiply
//   finishes from S_MULT; divide runs the restoring divider in S_DIVIDE, which
//   retires one quotient bit per cycle, and finishes from S_DIV_FIN.
//   One word is worked on at a time; op_stall is high from acceptance until the
//   result has been moved into the output register.
//   The output register lets a new word be accepted while an earlier result is
//   still stalled; a finishing word waits in place until that register frees.
//   Reset clears the entry count (empty stack) and the result valid flag; the
//   stack memory itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   op_valid,
	output logic                                   op_stall,
	input  logic [pse_pkg::OP_W-1:0]               operation,
	input  logic signed [pse_pkg::DATA_W-1:0]      value,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic signed [pse_pkg::DATA_W-1:0]      top_value,
	output logic [pse_pkg::DEPTH_W-1:0]            stack_depth,
	output logic [pse_pkg::STATUS_W-1:0]           status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int DW = pse_pkg::DATA_W + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	// Sequencer and stack pointer
	pse_pkg::state_t state_q, state_nx;
	logic [PW-1:0]   sp_q;
	logic [PW-1:0]   sp_m1, sp_m2;

	// Latched input word
	logic [pse_pkg::OP_W-1:0]          op_q;
	logic signed [pse_pkg::DATA_W-1:0] value_q;

	// Stack memory, two read ports, one write port
	logic signed [pse_pkg::DATA_W-1:0] mem [STACK_DEPTH];
	logic                              rd_en;
	logic signed [pse_pkg::DATA_W-1:0] rd_top_q, rd_sec_q;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic signed [pse_pkg::DATA_W-1:0] wr_data;

	// Finish of a word
	logic                              fin_req, fin_go, fin_we;
	logic [AW-1:0]                     fin_addr;
	logic signed [pse_pkg::DATA_W-1:0] fin_data;
	logic signed [pse_pkg::DATA_W-1:0] fin_top;
	logic [PW-1:0]                     fin_sp;
	pse_pkg::status_t                  fin_status;
	logic [PW+pse_pkg::DEPTH_W-1:0]    fin_sp_ext;

	// Output register
	logic                              res_valid_q;
	logic signed [pse_pkg::DATA_W-1:0] top_value_q;
	logic [pse_pkg::DEPTH_W-1:0]       stack_depth_q;
	logic [pse_pkg::STATUS_W-1:0]      status_q;
	logic                              out_free;

	// Datapath helpers
	logic                              underflow, full;
	logic signed [pse_pkg::DATA_W-1:0] top_cur;
	logic signed [pse_pkg::DATA_W:0]   as_sum;
	logic                              as_sat;
	logic signed [pse_pkg::DATA_W-1:0] as_res;
	logic signed [63:0]                mul_prod_q;
	logic signed [63:0]                mul_sh;
	logic                              mul_sat;
	logic signed [pse_pkg::DATA_W-1:0] mul_res;

	// Divider
	logic                              div_load;
	logic [pse_pkg::DATA_W-1:0]        abs_a, abs_b;
	logic [DW-1:0]                     dvd_q;
	logic [pse_pkg::DATA_W:0]          rem_q;
	logic [pse_pkg::DATA_W-1:0]        dvs_q;
	logic                              div_neg_q;
	logic [CW-1:0]                     div_cnt_q;
	logic [pse_pkg::DATA_W:0]          rem_sh;
	logic [pse_pkg::DATA_W+1:0]        rem_diff;
	logic                              q_bit;
	logic [63:0]                       quo_ext;
	logic                              div_sat;
	logic signed [pse_pkg::DATA_W-1:0] div_res;

	// Port drives
	assign op_stall    = (state_q != pse_pkg::S_IDLE);
	assign res_valid   = res_valid_q;
	assign top_value   = top_value_q;
	assign stack_depth = stack_depth_q;
	assign status      = status_q;
	assign out_free    = !res_valid_q || !res_stall;

	// Pointer arithmetic
	assign sp_m1     = sp_q - PW'(1);
	assign sp_m2     = sp_q - PW'(2);
	assign underflow = (sp_q < PW'(2));
	assign full      = (sp_q == PW'(STACK_DEPTH));
	assign top_cur   = (sp_q != '0) ? rd_top_q : '0;

	// Add / subtract with saturation
	always_comb begin
		if (op_q == pse_pkg::OP_SUB) begin
			as_sum = (pse_pkg::DATA_W+1)'(rd_sec_q) - (pse_pkg::DATA_W+1)'(rd_top_q);
		end else begin
			as_sum = (pse_pkg::DATA_W+1)'(rd_sec_q) + (pse_pkg::DATA_W+1)'(rd_top_q);
		end
		as_sat = (as_sum[pse_pkg::DATA_W] != as_sum[pse_pkg::DATA_W-1]);
		if (as_sat) begin
			as_res = as_sum[pse_pkg::DATA_W] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
		end else begin
			as_res = as_sum[pse_pkg::DATA_W-1:0];
		end
	end

	// Multiply: arithmetic shift rounds toward minus infinity, then clamp
	always_comb begin
		mul_sh  = mul_prod_q >>> FRAC_BITS;
		mul_sat = 1'b0;
		mul_res = mul_sh[pse_pkg::DATA_W-1:0];
		if (mul_sh > 64'sh0000_0000_7FFF_FFFF) begin
			mul_sat = 1'b1;
			mul_res = pse_pkg::Q_MAX;
		end else if (mul_sh < -64'sh0000_0000_8000_0000) begin
			mul_sat = 1'b1;
			mul_res = pse_pkg::Q_MIN;
		end
	end

	// Divider operands and one restoring step
	assign abs_a    = rd_sec_q[pse_pkg::DATA_W-1] ? (~rd_sec_q + 32'sd1) : rd_sec_q;
	assign abs_b    = rd_top_q[pse_pkg::DATA_W-1] ? (~rd_top_q + 32'sd1) : rd_top_q;
	assign rem_sh   = {rem_q[pse_pkg::DATA_W-1:0], dvd_q[DW-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign q_bit    = !rem_diff[pse_pkg::DATA_W+1];

	// Divide: sign fix and clamp of the magnitude quotient
	always_comb begin
		quo_ext = 64'(dvd_q);
		div_sat = 1'b0;
		if (div_neg_q) begin
			div_res = -$signed(quo_ext[pse_pkg::DATA_W-1:0]);
			if (quo_ext > 64'h0000_0000_8000_0000) begin
				div_sat = 1'b1;
				div_res = pse_pkg::Q_MIN;
			end
		end else begin
			div_res = $signed(quo_ext[pse_pkg::DATA_W-1:0]);
			if (quo_ext > 64'h0000_0000_7FFF_FFFF) begin
				div_sat = 1'b1;
				div_res = pse_pkg::Q_MAX;
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and finish selection
	always_comb begin
		state_nx   = state_q;
		rd_en      = 1'b0;
		div_load   = 1'b0;
		fin_req    = 1'b0;
		fin_we     = 1'b0;
		fin_addr   = sp_m2[AW-1:0];
		fin_data   = as_res;
		fin_top    = top_cur;
		fin_sp     = sp_q;
		fin_status = pse_pkg::ST_OK;
		case (state_q)
			pse_pkg::S_IDLE: begin
				if (op_valid) begin
					state_nx = pse_pkg::S_READ;
				end
			end
			pse_pkg::S_READ: begin
				rd_en    = 1'b1;
				state_nx = pse_pkg::S_EXEC;
			end
			pse_pkg::S_EXEC: begin
				case (op_q)
					pse_pkg::OP_PUSH: begin
						fin_req = 1'b1;
						if (full) begin
							fin_status = pse_pkg::ST_OVERFLOW;
						end else begin
							fin_we   = 1'b1;
							fin_addr = sp_q[AW-1:0];
							fin_data = value_q;
							fin_top  = value_q;
							fin_sp   = sp_q + PW'(1);
						end
					end
					pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
						fin_req = 1'b1;
						if (underflow) begin
							fin_status = pse_pkg::ST_UNDERFLOW;
						end else begin
							fin_we     = 1'b1;
							fin_data   = as_res;
							fin_top    = as_res;
							fin_sp     = sp_m1;
							fin_status = as_sat ? pse_pkg::ST_SATURATED : pse_pkg::ST_OK;
						end
					end
					pse_pkg::OP_MUL: begin
						if (underflow) begin
							fin_req    = 1'b1;
							fin_status = pse_pkg::ST_UNDERFLOW;
						end else begin
							state_nx = pse_pkg::S_MULT;
						end
					end
					pse_pkg::OP_DIV: begin
						if (underflow) begin
							fin_req    = 1'b1;
							fin_status = pse_pkg::ST_UNDERFLOW;
						end else if (rd_top_q == '0) begin
							fin_req    = 1'b1;
							fin_status = pse_pkg::ST_DIVZERO;
						end else begin
							div_load = 1'b1;
							state_nx = pse_pkg::S_DIVIDE;
						end
					end
					default: begin
						fin_req = 1'b1;
					end
				endcase
			end
			pse_pkg::S_MULT: begin
				fin_req    = 1'b1;
				fin_we     = 1'b1;
				fin_data   = mul_res;
				fin_top    = mul_res;
				fin_sp     = sp_m1;
				fin_status = mul_sat ? pse_pkg::ST_SATURATED : pse_pkg::ST_OK;
			end
			pse_pkg::S_DIVIDE: begin
				if (div_cnt_q == CW'(1)) begin
					state_nx = pse_pkg::S_DIV_FIN;
				end
			end
			pse_pkg::S_DIV_FIN: begin
				fin_req    = 1'b1;
				fin_we     = 1'b1;
				fin_data   = div_res;
				fin_top    = div_res;
				fin_sp     = sp_m1;
				fin_status = div_sat ? pse_pkg::ST_SATURATED : pse_pkg::ST_OK;
			end
			default: begin
				state_nx = pse_pkg::S_IDLE;
			end
		endcase
		fin_go = fin_req && out_free;
		if (fin_go) begin
			state_nx = pse_pkg::S_IDLE;
		end
	end

	assign wr_en      = fin_go && fin_we;
	assign wr_addr    = fin_addr;
	assign wr_data    = fin_data;
	assign fin_sp_ext = {{pse_pkg::DEPTH_W{1'b0}}, fin_sp};

	// Stack memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_top_q <= mem[sp_m1[AW-1:0]];
			rd_sec_q <= mem[sp_m2[AW-1:0]];
		end
	end

	// Input word latch
	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			op_q    <= operation;
			value_q <= value;
		end
	end

	// Stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (fin_go) begin
			sp_q <= fin_sp;
		end
	end

	// Multiplier product register
	always_ff @(posedge clk) begin
		if (state_q == pse_pkg::S_EXEC) begin
			mul_prod_q <= rd_sec_q * rd_top_q;
		end
	end

	// Restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (div_load) begin
			dvd_q     <= DW'(abs_a) << FRAC_BITS;
			dvs_q     <= abs_b;
			rem_q     <= '0;
			div_neg_q <= rd_sec_q[pse_pkg::DATA_W-1] ^ rd_top_q[pse_pkg::DATA_W-1];
			div_cnt_q <= CW'(DW);
		end else if (state_q == pse_pkg::S_DIVIDE) begin
			rem_q     <= q_bit ? rem_diff[pse_pkg::DATA_W:0] : rem_sh;
			dvd_q     <= {dvd_q[DW-2:0], q_bit};
			div_cnt_q <= div_cnt_q - CW'(1);
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fin_go) begin
			top_value_q   <= fin_top;
			stack_depth_q <= fin_sp_ext[pse_pkg::DEPTH_W-1:0];
			status_q      <= fin_status;
		end
	end

endmodule

// ===== sv/pse_checker.sv =====
// Port-level assertion checker of the postfix stack evaluator, with its bind.
// Depends on pse_pkg and postfix_stack_evaluator_assert.svh.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_assert.svh"

module pse_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              op_valid,
	input logic                              op_stall,
	input logic [pse_pkg::OP_W-1:0]          operation,
	input logic signed [pse_pkg::DATA_W-1:0] value,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic signed [pse_pkg::DATA_W-1:0] top_value,
	input logic [pse_pkg::DEPTH_W-1:0]       stack_depth,
	input logic [pse_pkg::STATUS_W-1:0]      status
);

	logic in_word, in_held, res_held, res_uflow;
	logic [pse_pkg::OP_W+pse_pkg::DATA_W-1:0]                       in_payload;
	logic [pse_pkg::DATA_W+pse_pkg::DEPTH_W+pse_pkg::STATUS_W-1:0] res_word;

	assign in_word    = op_valid && !op_stall;
	assign in_held    = op_valid && op_stall;
	assign res_held   = res_valid && res_stall;
	assign res_uflow  = res_valid && (status == pse_pkg::ST_UNDERFLOW);
	assign in_payload = {operation, value};
	assign res_word   = {top_value, stack_depth, status};

	// A stalled input word holds
	`PSE_ASSERT_NXT(a_in_hold, in_held, $stable(in_payload), "stalled input word changed")

	// A stalled result word holds
	`PSE_ASSERT_NXT(a_res_hold, res_held, res_valid && $stable(res_word), "stalled result word changed")

	// One word in flight: the input side is busy right after acceptance
	`PSE_ASSERT_NXT(a_busy_after_accept, in_word, op_stall, "input accepted twice in a row")

	// Underflow is only reported with fewer than two entries
	`PSE_ASSERT_IMP(a_underflow_depth, res_uflow, stack_depth < 5'd2, "underflow with two or more entries")

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.op_valid    (op_valid),
	.op_stall    (op_stall),
	.operation   (operation),
	.value       (value),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.top_value   (top_value),
	.stack_depth (stack_depth),
	.status      (status)
);
